/* sv/zcrms_pkg.sv */
// zcrms_pkg: shared types and fixed constants of the zero-crossing RMS meter.
// Used by zcrms_ctrl, zcrms_datapath and the top level. No dependencies.
`default_nettype none

package zcrms_pkg;

   // fixed output field widths
   localparam int CROSS_W   = 8;
   localparam int RUN_RMS_W = 18;
   localparam int WIN_RMS_W = 20;
   localparam int CNT_OUT_W = 24;

   localparam logic [CROSS_W-1:0] CFG_RESET = 8'd50;

   // scaled mean is 62 bits, plus the clamp value 2^62
   localparam int MEAN_W     = 63;
   localparam int ROOT_RES_W = 64;
   localparam logic [MEAN_W-1:0]     MEAN_CLAMP = 63'h4000_0000_0000_0000;
   localparam logic [ROOT_RES_W-1:0] ROOT_MAX   = 64'h0000_0000_8000_0000;

   // volts: r/16000 = (r>>7)/125, 5r/16000 = (r>>7)/25, by reciprocal multiply
   localparam int SCALE_PRE_SHIFT = 7;
   localparam int RECIP_W   = 25;
   localparam int PROD_W    = 2 * RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_RUN = 25'd17179870; // ceil(2^31/125)
   localparam logic [RECIP_W-1:0] RECIP_WIN = 25'd21474837; // ceil(2^29/25)
   localparam int RUN_SHIFT = 31;
   localparam int WIN_SHIFT = 29;

   typedef struct packed {
      logic load;
      logic eval;
      logic accum;
      logic div_start;
      logic div_step;
      logic root_start;
      logic root_step;
      logic mul;
      logic store;
      logic emit;
      logic phase_run;   // 0: closed-window pass, 1: running pass
   } zcrms_cmd_type;

   typedef struct packed {
      logic close;
      logic div_last;
      logic root_last;
      logic out_free;
   } zcrms_status_type;

endpackage

`default_nettype wire

/* sv/zero_cross_windowed_rms_meter.sv */
// Zero-crossing windowed true-RMS meter, top level.
// req_ channel: one signed ADC sample per beat (valid/stall, stall from this block).
// rsp_ channel: one result beat per sample: running RMS, sample count, crossing
//   count, and on a closing crossing window_done with five times the window RMS.
//   Volts are unsigned fixed point with 16 fractional bits.
// csr_ channel: writes crossings_per_window (valid/ready, ready is always high);
//   write it only while no sample is in flight.
// Sequence: each pass runs the one-bit-per-cycle divider of N steps, with
//   N = SUM_WIDTH + 62 - 2*(SAMPLE_WIDTH-1) (86 at the defaults), then the
//   square root of 32 steps; a sample that closes a window first takes a
//   window pass, then the running pass. One sample is worked at a time: the
//   next sample is accepted only after the last one's result is emitted.
// A finished result sits in an output register; the next sample is accepted
//   while it waits, and the block holds in its last step if rsp_stall is still
//   high when the next result is ready.
// Reset (synchronous): clears the window, sets crossings_per_window to 50 and
//   drops rsp_valid. The block accepts a sample in the first cycle after reset.
`default_nettype none

module zero_cross_windowed_rms_meter
   import zcrms_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COUNT_WIDTH  = 24
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [SAMPLE_WIDTH-1:0]  req_sample_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [RUN_RMS_W-1:0]          rsp_running_rms,
   output logic [CNT_OUT_W-1:0]          rsp_sample_count,
   output logic [CROSS_W-1:0]            rsp_crossing_count,
   output logic                          rsp_window_done,
   output logic [WIN_RMS_W-1:0]          rsp_window_rms,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CROSS_W-1:0]       csr_crossings_per_window
);

   zcrms_cmd_type    cmd;
   zcrms_status_type status;

   assign csr_ready = 1'b1;

   zcrms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   zcrms_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_datapath (
      .clock                    (clock),
      .reset                    (reset),
      .cmd                      (cmd),
      .status                   (status),
      .req_sample_value         (req_sample_value),
      .csr_valid                (csr_valid),
      .csr_crossings_per_window (csr_crossings_per_window),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_running_rms          (rsp_running_rms),
      .rsp_sample_count         (rsp_sample_count),
      .rsp_crossing_count       (rsp_crossing_count),
      .rsp_window_done          (rsp_window_done),
      .rsp_window_rms           (rsp_window_rms)
   );

endmodule

`default_nettype wire

/* sv/zcrms_ctrl.sv */
// zcrms_ctrl: sequencer of the RMS meter; issues datapath commands per sample.
// Depends on zcrms_pkg.
`default_nettype none

module zcrms_ctrl
   import zcrms_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire zcrms_status_type status,
   output zcrms_cmd_type         cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_EVAL   = 4'd1;
   localparam logic [3:0] ST_ACCUM  = 4'd2;
   localparam logic [3:0] ST_DSTART = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_RSTART = 4'd5;
   localparam logic [3:0] ST_ROOT   = 4'd6;
   localparam logic [3:0] ST_MUL    = 4'd7;
   localparam logic [3:0] ST_STORE  = 4'd8;
   localparam logic [3:0] ST_EMIT   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       phase_ff, phase_in;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cmd           = '0;
      cmd.phase_run = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            // a closing crossing first measures the window as it stood
            phase_in = !status.close;
            state_in = status.close ? ST_DSTART : ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            phase_in  = 1'b1;
            state_in  = ST_DSTART;
         end
         ST_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_RSTART;
         end
         ST_RSTART: begin
            cmd.root_start = 1'b1;
            state_in       = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (status.root_last) state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = phase_ff ? ST_EMIT : ST_STORE;
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = ST_ACCUM;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

/* sv/zcrms_datapath.sv */
// zcrms_datapath: window state, bit-serial divider, bit-serial square root,
// volt scaling and the result register. Depends on zcrms_pkg.
`default_nettype none

module zcrms_datapath
   import zcrms_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COUNT_WIDTH  = 24
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire zcrms_cmd_type            cmd,
   output zcrms_status_type              status,
   input  wire logic [SAMPLE_WIDTH-1:0]  req_sample_value,
   input  wire logic                     csr_valid,
   input  wire logic [CROSS_W-1:0]       csr_crossings_per_window,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [RUN_RMS_W-1:0]          rsp_running_rms,
   output logic [CNT_OUT_W-1:0]          rsp_sample_count,
   output logic [CROSS_W-1:0]            rsp_crossing_count,
   output logic                          rsp_window_done,
   output logic [WIN_RMS_W-1:0]          rsp_window_rms
);

   localparam int SUM_RAW   = 2 * (SAMPLE_WIDTH - 1) + COUNT_WIDTH;
   localparam int SUM_WIDTH = (SUM_RAW > 63) ? 63 : SUM_RAW;
   localparam int FRAC_BITS = 62 - 2 * (SAMPLE_WIDTH - 1);
   localparam int DIV_STEPS = SUM_WIDTH + FRAC_BITS;
   localparam int DSTEP_W   = $clog2(DIV_STEPS);

   // sample and window state
   logic [SAMPLE_WIDTH-1:0]   sample_ff;
   logic                      neg_w;
   logic [SAMPLE_WIDTH-1:0]   mag_w;
   logic [2*SAMPLE_WIDTH-1:0] sq_prod_w;
   logic [SUM_WIDTH-1:0]      sq_ff;
   logic                      prev_neg_ff;
   logic                      close_ff;
   logic                      rising_w, close_w;
   logic [CROSS_W-1:0]        cfg_ff;
   logic [CROSS_W-1:0]        cross_ff, cross_in, cross_inc_w;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [SUM_WIDTH-1:0]      sum_ff, sum_in;
   logic [SUM_WIDTH:0]        sum_add_w;

   // divider
   logic [SUM_WIDTH-1:0]      dvd_ff;
   logic [COUNT_WIDTH-1:0]    rem_ff, rem_in;
   logic [COUNT_WIDTH:0]      rem_sh_w, rem_diff_w;
   logic                      qbit_w;
   logic [MEAN_W-1:0]         quo_ff;
   logic                      ovf_ff;
   logic                      dzero_ff;
   logic [DSTEP_W-1:0]        dstep_ff;
   logic [MEAN_W-1:0]         mean_w;

   // square root
   logic [MEAN_W-1:0]         rv_ff, rv_in;
   logic [ROOT_RES_W-1:0]     res_ff, res_in;
   logic [MEAN_W-1:0]         rbit_ff;
   logic [ROOT_RES_W:0]       trial_w;
   logic                      fit_w;

   // scaling and results
   logic [RECIP_W-1:0]        scale_x_w, recip_w;
   logic [PROD_W-1:0]         prod_ff;
   logic                      done_ff;
   logic [WIN_RMS_W-1:0]      wrms_ff;
   logic [COUNT_WIDTH+CNT_OUT_W-1:0] cnt_ext_w;
   logic                      rsp_valid_ff;
   logic [RUN_RMS_W-1:0]      rsp_run_ff;
   logic [CNT_OUT_W-1:0]      rsp_cnt_ff;
   logic [CROSS_W-1:0]        rsp_cross_ff;
   logic                      rsp_done_ff;
   logic [WIN_RMS_W-1:0]      rsp_wrms_ff;

   // ---------------- sample, crossings, accumulation ----------------
   assign neg_w       = sample_ff[SAMPLE_WIDTH-1];
   assign mag_w       = neg_w ? (~sample_ff + 1'b1) : sample_ff;
   assign sq_prod_w   = mag_w * mag_w;
   assign rising_w    = !neg_w && prev_neg_ff;
   assign cross_inc_w = cross_ff + 1'b1;
   assign close_w     = rising_w && (cross_inc_w == cfg_ff);
   assign cross_in    = !rising_w ? cross_ff : (close_w ? '0 : cross_inc_w);

   assign sum_add_w = {1'b0, sum_ff} + {1'b0, sq_ff};
   always_comb begin
      if (close_ff) begin
         sum_in   = sq_ff;
         count_in = COUNT_WIDTH'(1);
      end else begin
         sum_in   = sum_add_w[SUM_WIDTH] ? '1 : sum_add_w[SUM_WIDTH-1:0];
         count_in = (&count_ff) ? count_ff : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) sample_ff <= req_sample_value;
      if (cmd.eval) sq_ff <= {{(SUM_WIDTH-2*SAMPLE_WIDTH){1'b0}}, sq_prod_w};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= CFG_RESET;
         prev_neg_ff <= 1'b0;
         cross_ff    <= '0;
         count_ff    <= '0;
         sum_ff      <= '0;
         close_ff    <= 1'b0;
      end else begin
         if (csr_valid) cfg_ff <= csr_crossings_per_window;
         if (cmd.eval) begin
            cross_ff <= cross_in;
            close_ff <= close_w;
         end
         if (cmd.accum) begin
            sum_ff      <= sum_in;
            count_ff    <= count_in;
            prev_neg_ff <= neg_w;
         end
      end
   end

   // ---------------- restoring divider: (sum << FRAC_BITS) / count ----------------
   assign rem_sh_w   = {rem_ff, dvd_ff[SUM_WIDTH-1]};
   assign rem_diff_w = rem_sh_w - {1'b0, count_ff};
   assign qbit_w     = ~rem_diff_w[COUNT_WIDTH];
   assign rem_in     = qbit_w ? rem_diff_w[COUNT_WIDTH-1:0] : rem_sh_w[COUNT_WIDTH-1:0];
   // quotient at or above 2^62 means the mean is clamped to full scale
   assign mean_w     = dzero_ff ? '0 : ((ovf_ff || quo_ff[MEAN_W-1]) ? MEAN_CLAMP : quo_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff   <= sum_ff;
         rem_ff   <= '0;
         quo_ff   <= '0;
         ovf_ff   <= 1'b0;
         dzero_ff <= (count_ff == '0);
         dstep_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff   <= {dvd_ff[SUM_WIDTH-2:0], 1'b0};
         rem_ff   <= rem_in;
         quo_ff   <= {quo_ff[MEAN_W-2:0], qbit_w};
         ovf_ff   <= ovf_ff | quo_ff[MEAN_W-1];
         dstep_ff <= dstep_ff + 1'b1;
      end
   end

   // ---------------- square root, two bits of the radicand per step ----------------
   assign trial_w = {1'b0, res_ff} + {2'b0, rbit_ff};
   assign fit_w   = ({2'b0, rv_ff} >= trial_w);
   assign rv_in   = fit_w ? (rv_ff - trial_w[MEAN_W-1:0]) : rv_ff;
   assign res_in  = fit_w ? ((res_ff >> 1) + {1'b0, rbit_ff}) : (res_ff >> 1);

   always_ff @(posedge clock) begin
      if (cmd.root_start) begin
         rv_ff   <= mean_w;
         res_ff  <= '0;
         rbit_ff <= MEAN_CLAMP;
      end else if (cmd.root_step) begin
         rv_ff   <= rv_in;
         res_ff  <= res_in;
         rbit_ff <= rbit_ff >> 2;
      end
   end

   // ---------------- volt scaling ----------------
   assign scale_x_w = res_ff[SCALE_PRE_SHIFT +: RECIP_W];
   assign recip_w   = cmd.phase_run ? RECIP_RUN : RECIP_WIN;

   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= scale_x_w * recip_w;
      if (cmd.load) begin
         done_ff <= 1'b0;
         wrms_ff <= '0;
      end else if (cmd.store && !cmd.phase_run) begin
         done_ff <= 1'b1;
         wrms_ff <= prod_ff[WIN_SHIFT +: WIN_RMS_W];
      end
   end

   // ---------------- result register ----------------
   assign cnt_ext_w = {{CNT_OUT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_run_ff   <= prod_ff[RUN_SHIFT +: RUN_RMS_W];
         rsp_cnt_ff   <= cnt_ext_w[CNT_OUT_W-1:0];
         rsp_cross_ff <= cross_ff;
         rsp_done_ff  <= done_ff;
         rsp_wrms_ff  <= wrms_ff;
      end
   end

   assign status.close     = close_w;
   assign status.div_last  = (dstep_ff == DSTEP_W'(DIV_STEPS - 1));
   assign status.root_last = rbit_ff[0];
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_running_rms    = rsp_run_ff;
   assign rsp_sample_count   = rsp_cnt_ff;
   assign rsp_crossing_count = rsp_cross_ff;
   assign rsp_window_done    = rsp_done_ff;
   assign rsp_window_rms     = rsp_wrms_ff;

   // a window always holds at least the sample that opened it
   a_div_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (count_ff != '0))
      else $error("divider started on an empty window");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |-> (res_ff <= ROOT_MAX))
      else $error("square root above full scale");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten before it was taken");

   a_store_on_close: assert property (@(posedge clock) disable iff (reset)
      (cmd.store && !cmd.phase_run) |-> close_ff)
      else $error("window result stored without a closing crossing");

   a_done_clears_cross: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_cross_ff == '0))
      else $error("closed window reports nonzero crossings");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// tb_top: self-checking bench for zero_cross_windowed_rms_meter.
// Depends on zcrms_pkg and the meter top level. A scoreboard class predicts every
// result beat; tasks drive sample beats with random idles and csr writes, and the result side stalls at random.
`timescale 1ns / 100ps

module tb_top;
   import zcrms_pkg::*;

   localparam int SAMPLE_W      = 16;
   localparam int COUNT_W       = 24;
   localparam int SUM_W         = 2 * (SAMPLE_W - 1) + COUNT_W;
   localparam int FRAC_W        = 62 - 2 * (SAMPLE_W - 1);
   localparam int SETTLE_CYCLES = 260;
   localparam int STALL_LIMIT   = 3000;
   localparam int MAX_WAIT      = 13;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [RUN_RMS_W-1:0] running_rms;
      logic [CNT_OUT_W-1:0] sample_count;
      logic [CROSS_W-1:0]   crossing_count;
      logic                 window_done;
      logic [WIN_RMS_W-1:0] window_rms;
   } meter_reading_type;

   class rms_scoreboard;
      localparam logic [63:0] SQUARE_SUM_MAX   = (64'd1 << SUM_W) - 64'd1;
      localparam logic [63:0] SAMPLE_COUNT_MAX = (64'd1 << COUNT_W) - 64'd1;
      localparam logic [63:0] MEAN_LIMIT       = 64'd1 << (2 * (SAMPLE_W - 1));
      localparam logic [63:0] VOLT_DIV         = 64'd16000;

      logic [CROSS_W-1:0] window_target;
      logic               last_was_negative;
      logic [CROSS_W-1:0] crossings_seen;
      logic [63:0]        samples_seen;
      logic [63:0]        squares_total;
      meter_reading_type  expected_readings[$];
      int                 faults;

      function new();
         window_target     = CFG_RESET;
         last_was_negative = 1'b0;
         crossings_seen    = '0;
         samples_seen      = '0;
         squares_total     = '0;
         faults            = 0;
      endfunction

      function void set_target(logic [CROSS_W-1:0] target);
         window_target = target;
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      function logic [63:0] floor_sqrt(logic [63:0] v);
         logic [63:0] root;
         logic [63:0] probe;
         root  = '0;
         probe = 64'd1 << 62;
         while (probe > v)
            probe = probe >> 2;
         while (probe != 0) begin
            if (v >= root + probe) begin
               v    = v - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root = root >> 1;
            end
            probe = probe >> 2;
         end
         return root;
      endfunction

      // sqrt of sum/count, carrying FRAC_W/2 fractional bits
      function logic [63:0] mean_root(logic [63:0] sum, logic [63:0] count);
         logic [63:0] quot;
         logic [63:0] rem;
         logic [63:0] frac;
         logic [63:0] mean;
         int          i;
         if (count == 0)
            return '0;
         quot = sum / count;
         rem  = sum % count;
         frac = '0;
         for (i = 0; i < FRAC_W; i++) begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= count) begin
               rem     = rem - count;
               frac[0] = 1'b1;
            end
         end
         if (quot >= MEAN_LIMIT)
            mean = MEAN_LIMIT << FRAC_W;
         else
            mean = (quot << FRAC_W) | frac;
         return floor_sqrt(mean);
      endfunction

      function meter_reading_type predict_reading(logic [SAMPLE_W-1:0] s);
         meter_reading_type rd;
         logic              neg;
         logic [63:0]       mag;
         logic [63:0]       sq;
         logic [63:0]       root;
         neg = s[SAMPLE_W-1];
         mag = neg ? ((64'd1 << SAMPLE_W) - 64'(s)) : 64'(s);
         sq  = mag * mag;
         rd  = '0;
         if (!neg && last_was_negative) begin
            crossings_seen = crossings_seen + 1'b1;
            if (crossings_seen == window_target) begin
               // window rms excludes the closing sample
               root           = mean_root(squares_total, samples_seen);
               rd.window_rms  = WIN_RMS_W'((64'd5 * root) / VOLT_DIV);
               rd.window_done = 1'b1;
               samples_seen   = '0;
               squares_total  = '0;
               crossings_seen = '0;
            end
         end
         if (squares_total > SQUARE_SUM_MAX - sq)
            squares_total = SQUARE_SUM_MAX;
         else
            squares_total = squares_total + sq;
         if (samples_seen < SAMPLE_COUNT_MAX)
            samples_seen = samples_seen + 64'd1;
         last_was_negative = neg;
         root              = mean_root(squares_total, samples_seen);
         rd.running_rms    = RUN_RMS_W'(root / VOLT_DIV);
         rd.sample_count   = CNT_OUT_W'(samples_seen);
         rd.crossing_count = crossings_seen;
         return rd;
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] s);
         expected_readings.push_back(predict_reading(s));
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            faults++;
            if (faults <= REPORT_LIMIT)
               $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_reading(logic [RUN_RMS_W-1:0] running_rms,
                                  logic [CNT_OUT_W-1:0] sample_count,
                                  logic [CROSS_W-1:0] crossing_count,
                                  logic window_done,
                                  logic [WIN_RMS_W-1:0] window_rms);
         meter_reading_type want;
         if (expected_readings.size() == 0) begin
            faults++;
            if (faults <= REPORT_LIMIT)
               $display("%0t: result beat with no sample pending", $time);
            return;
         end
         want = expected_readings.pop_front();
         compare_field("running_rms", 32'(want.running_rms), 32'(running_rms));
         compare_field("sample_count", 32'(want.sample_count), 32'(sample_count));
         compare_field("crossing_count", 32'(want.crossing_count), 32'(crossing_count));
         compare_field("window_done", 32'(want.window_done), 32'(window_done));
         compare_field("window_rms", 32'(want.window_rms), 32'(window_rms));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [SAMPLE_W-1:0]  req_sample_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [RUN_RMS_W-1:0] rsp_running_rms;
   logic [CNT_OUT_W-1:0] rsp_sample_count;
   logic [CROSS_W-1:0]   rsp_crossing_count;
   logic                 rsp_window_done;
   logic [WIN_RMS_W-1:0] rsp_window_rms;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CROSS_W-1:0]   csr_crossings_per_window;

   rms_scoreboard meter = new();

   // wave generator state
   logic wave_negative = 1'b0;
   int   run_left      = 0;
   int   max_run       = 1;
   bit   no_idle       = 1'b0;
   int   idle_cycles   = 0;

   logic [SAMPLE_W-1:0] corner_samples[$] = '{
      16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h8000,
      16'h7FFF, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA, 16'h7FFE, 16'h8001, 16'h00FF,
      16'hFF00, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000};

   zero_cross_windowed_rms_meter #(
      .SAMPLE_WIDTH (SAMPLE_W),
      .COUNT_WIDTH  (COUNT_W)
   ) dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_sample_value         (req_sample_value),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_running_rms          (rsp_running_rms),
      .rsp_sample_count         (rsp_sample_count),
      .rsp_crossing_count       (rsp_crossing_count),
      .rsp_window_done          (rsp_window_done),
      .rsp_window_rms           (rsp_window_rms),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_crossings_per_window (csr_crossings_per_window)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int draw_wait();
      if (no_idle)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // mostly sign runs of random length and amplitude, some raw noise and corners
   function automatic logic [SAMPLE_W-1:0] next_wave_sample();
      int mag;
      if ($urandom_range(0, 9) == 0)
         return SAMPLE_W'($urandom);
      if ($urandom_range(0, 31) == 0) begin
         case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return 16'h0000;
         endcase
      end
      if (run_left == 0) begin
         wave_negative = !wave_negative;
         run_left      = $urandom_range(1, max_run);
      end
      run_left--;
      mag = $urandom_range(0, 32767) >> $urandom_range(0, 14);
      if (wave_negative)
         return SAMPLE_W'(-(mag + 1));
      return SAMPLE_W'(mag);
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_value <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      meter.note_sample(value);
   endtask

   task automatic settle();
      while (meter.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_target(input logic [CROSS_W-1:0] target);
      csr_valid                <= 1'b1;
      csr_crossings_per_window <= target;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      meter.set_target(target);
   endtask

   task automatic run_phase(input logic [CROSS_W-1:0] target, input int count,
                            input int run_max, input bit quiet);
      int i;
      settle();
      write_target(target);
      max_run = run_max;
      no_idle = quiet;
      for (i = 0; i < count; i++)
         send_sample(next_wave_sample());
      req_valid <= 1'b0;
   endtask

   // result side: stall for a drawn number of cycles, then take one beat
   initial begin : result_side
      int hold;
      rsp_stall <= 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         hold = draw_wait();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         meter.check_reading(rsp_running_rms, rsp_sample_count, rsp_crossing_count,
                             rsp_window_done, rsp_window_rms);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int i;
      reset                    <= 1'b1;
      req_valid                <= 1'b0;
      req_sample_value         <= '0;
      csr_valid                <= 1'b0;
      csr_crossings_per_window <= CFG_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners at the reset target; a window of only full-scale negatives
      // drives the mean clamp
      for (i = 0; i < corner_samples.size(); i++)
         send_sample(corner_samples[i]);
      req_valid <= 1'b0;

      run_phase(8'd1, 250, 4, 1'b0);
      run_phase(8'd255, 300, 1, 1'b0);
      // target drops below the live count: counter wraps, then closes every 256
      run_phase(8'd0, 400, 1, 1'b0);
      run_phase(8'd7, 200, 6, 1'b1);
      run_phase(8'd255, 600, 1, 1'b0);

      settle();
      if (meter.faults == 0 && meter.pending() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

/* filelist.f */
sv/zcrms_pkg.sv
sv/zcrms_ctrl.sv
sv/zcrms_datapath.sv
sv/zero_cross_windowed_rms_meter.sv
verif/tb_top.sv
